>>> src/vnag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnag_pkg
// Shared constants, types and helpers of the voxel neighbor address generator.
// ----------------------------------------------------------------------------
package vnag_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int SIZE_W      = $clog2(MAX_DIM) + 1;
  localparam int PLANE_W     = 2 * $clog2(MAX_DIM) + 1;
  localparam int CONN_W      = 2;
  localparam int ADDR_W      = 30;
  localparam int ORD_W       = 5;
  localparam int STAT_W      = 2;
  localparam int IDX_W       = 2;
  localparam int WIN_CELLS   = 27;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SIZE_Z = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_X = 2'd2,
    REG_CONN   = 2'd3
  } reg_idx_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_VALID = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // Step of one axis inside the 3x3x3 window
  typedef enum logic [1:0] {
    D_NEG  = 2'd0,
    D_ZERO = 2'd1,
    D_POS  = 2'd2
  } delta_e;

  typedef enum logic [1:0] {
    AXIS_Z = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_X = 2'd2
  } axis_e;

  // Configuration seen by the front end
  typedef struct packed {
    logic [SIZE_W-1:0] size_z;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_x;
    logic [CONN_W-1:0] conn;
  } cfg_t;

  // Classified job handed from front to back
  typedef struct packed {
    status_e              kind;
    logic [ADDR_W-1:0]    center;
    logic [WIN_CELLS-1:0] mask;
    logic [PLANE_W-1:0]   plane;
    logic [SIZE_W-1:0]    row;
  } job_t;

  // Step along one axis for a window cell in z-y-x scan order
  function automatic delta_e cell_delta(input int unsigned pos, input axis_e axis);
    int unsigned digit;
    unique case (axis)
      AXIS_Z:  digit = pos / 9;
      AXIS_Y:  digit = (pos / 3) % 3;
      default: digit = pos % 3;
    endcase
    return (digit == 0) ? D_NEG : ((digit == 1) ? D_ZERO : D_POS);
  endfunction

endpackage

>>> src/vnag_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnag_fifo
// Short job queue between the classifying front end and the emitting back end.
// ----------------------------------------------------------------------------
module vnag_fifo
  import vnag_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> src/vnag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnag_front
// Accept a center voxel, check its range, compute its linear address and the
// mask of window cells that are neighbors, then queue the job.
// ----------------------------------------------------------------------------
module vnag_front
  import vnag_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] coord_z_i,
  input  logic [COORD_W-1:0] coord_y_i,
  input  logic [COORD_W-1:0] coord_x_i,
  output logic               push_o,
  output job_t               job_o,
  input  logic               full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM
  } front_state_e;

  front_state_e state_q;

  logic [COORD_W-1:0] cz_q, cy_q, cx_q;
  logic               err_q;
  logic [ADDR_W-1:0]  pz_q, py_q;
  logic [PLANE_W-1:0] plane_q;

  logic [SIZE_W-1:0]          nzs, nys, nxs;
  logic [COORD_W+PLANE_W-1:0] pz_full;
  logic [COORD_W+SIZE_W-1:0]  py_full;
  logic [2*SIZE_W-1:0]        plane_full;
  logic [WIN_CELLS-1:0]       mask;
  logic                       in_err;

  // Saturate sizes to the largest supported dimension
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    return (s > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : s;
  endfunction

  // Check that one axis step stays inside the volume
  function automatic logic axis_ok(input delta_e d, input logic [COORD_W-1:0] c,
                                   input logic [SIZE_W-1:0] n);
    logic ok;
    unique case (d)
      D_NEG:   ok = (c != '0);
      D_POS:   ok = ((SIZE_W'(c) + SIZE_W'(1)) < n);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  assign nzs = eff_size(cfg_i.size_z);
  assign nys = eff_size(cfg_i.size_y);
  assign nxs = eff_size(cfg_i.size_x);

  assign in_err = (SIZE_W'(coord_z_i) >= nzs) || (SIZE_W'(coord_y_i) >= nys) ||
                  (SIZE_W'(coord_x_i) >= nxs);

  assign plane_full = nys * nxs;
  assign pz_full    = cz_q * plane_q;
  assign py_full    = cy_q * nxs;

  // Mark window cells that lie inside the volume and within the distance limit
  always_comb begin
    delta_e     dz, dy, dx;
    logic [1:0] hops;
    mask = '0;
    for (int i = 0; i < WIN_CELLS; i++) begin
      dz   = cell_delta(i, AXIS_Z);
      dy   = cell_delta(i, AXIS_Y);
      dx   = cell_delta(i, AXIS_X);
      hops = 2'(dz != D_ZERO) + 2'(dy != D_ZERO) + 2'(dx != D_ZERO);
      mask[i] = axis_ok(dz, cz_q, nzs) && axis_ok(dy, cy_q, nys) &&
                axis_ok(dx, cx_q, nxs) && (hops != 2'd0) && (hops <= cfg_i.conn);
    end
  end

  // Assemble the job
  always_comb begin
    job_o.center = pz_q + py_q + ADDR_W'(cx_q);
    job_o.mask   = mask;
    job_o.plane  = plane_q;
    job_o.row    = nxs;
    if (err_q) begin
      job_o.kind = ST_ERROR;
    end else if (mask == '0) begin
      job_o.kind = ST_EMPTY;
    end else begin
      job_o.kind = ST_VALID;
    end
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_SUM) && !full_i;

  // Track the plane size of the current configuration
  always_ff @(posedge clk_i) begin
    plane_q <= PLANE_W'(plane_full);
  end

  // Sequence accept, multiply and queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      err_q   <= 1'b0;
      cz_q    <= '0;
      cy_q    <= '0;
      cx_q    <= '0;
      pz_q    <= '0;
      py_q    <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            cz_q    <= coord_z_i;
            cy_q    <= coord_y_i;
            cx_q    <= coord_x_i;
            err_q   <= in_err;
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          pz_q    <= ADDR_W'(pz_full);
          py_q    <= ADDR_W'(py_full);
          state_q <= F_SUM;
        end
        F_SUM: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

>>> src/vnag_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnag_back
// Take queued jobs and emit one neighbor address per beat in scan order,
// or a single marker beat for empty and out-of-range centers.
// ----------------------------------------------------------------------------
module vnag_back
  import vnag_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] nbr_addr_o,
  output logic [ORD_W-1:0]  ordinal_o,
  output logic              last_o,
  output logic [STAT_W-1:0] status_o
);

  logic                 busy_q;
  job_t                 job_q;
  logic [WIN_CELLS-1:0] mask_q;
  logic [ORD_W-1:0]     ord_q;

  logic                 out_valid_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [ORD_W-1:0]     ordo_q;
  logic                 last_q;
  status_e              status_q;

  logic                 adv;
  logic [WIN_CELLS-1:0] sel, rest;
  delta_e               dz, dy, dx;
  logic [ADDR_W-1:0]    plane_ext, row_ext, tz, ty, tx, addr_next;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = !busy_q && !empty_i;

  // Pick the lowest remaining window cell
  assign sel  = mask_q & (~mask_q + WIN_CELLS'(1));
  assign rest = mask_q & ~sel;

  always_comb begin
    dz = D_ZERO;
    dy = D_ZERO;
    dx = D_ZERO;
    for (int i = 0; i < WIN_CELLS; i++) begin
      if (sel[i]) begin
        dz = cell_delta(i, AXIS_Z);
        dy = cell_delta(i, AXIS_Y);
        dx = cell_delta(i, AXIS_X);
      end
    end
  end

  // Offset the center address by one step per axis
  assign plane_ext = ADDR_W'(job_q.plane);
  assign row_ext   = ADDR_W'(job_q.row);

  always_comb begin
    case (dz)
      D_NEG:   tz = ADDR_W'(0) - plane_ext;
      D_POS:   tz = plane_ext;
      default: tz = '0;
    endcase
    case (dy)
      D_NEG:   ty = ADDR_W'(0) - row_ext;
      D_POS:   ty = row_ext;
      default: ty = '0;
    endcase
    case (dx)
      D_NEG:   tx = ADDR_W'(0) - ADDR_W'(1);
      D_POS:   tx = ADDR_W'(1);
      default: tx = '0;
    endcase
  end

  assign addr_next = job_q.center + tz + ty + tx;

  // Hold the job payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  // Load jobs, walk the mask and drive the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      ord_q       <= '0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      ordo_q      <= '0;
      last_q      <= 1'b0;
      status_q    <= ST_VALID;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        mask_q <= job_i.mask;
        ord_q  <= '0;
      end
      if (adv) begin
        out_valid_q <= busy_q;
        if (busy_q) begin
          if (job_q.kind == ST_VALID) begin
            addr_q   <= addr_next;
            ordo_q   <= ord_q + ORD_W'(1);
            last_q   <= (rest == '0);
            status_q <= ST_VALID;
            ord_q    <= ord_q + ORD_W'(1);
            mask_q   <= rest;
            busy_q   <= (rest != '0);
          end else begin
            addr_q   <= '0;
            ordo_q   <= '0;
            last_q   <= 1'b1;
            status_q <= job_q.kind;
            busy_q   <= 1'b0;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign nbr_addr_o  = addr_q;
  assign ordinal_o   = ordo_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

>>> src/voxel_neighbor_address_gen_unit.sv
`timescale 1ns / 1ps
// Path: an accepted item passes the front end's multiply and sum states, the job
// queue, the back end's job register and its output register before its first beat.
// Throughput: the front end takes one item at a time through these states; the back
// end loads one job, then emits one result per cycle (n neighbors, or 1 marker) while
// the output is not stalled, and takes no new job until its last result is out.
// Reset: sizes return to 1, connectivity to 3, the job queue and output empty.
// ----------------------------------------------------------------------------
// voxel_neighbor_address_gen_unit
// Emits the linear addresses of the 6/18/26-connected neighbors of a voxel.
// ----------------------------------------------------------------------------
module voxel_neighbor_address_gen_unit
  import vnag_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [SIZE_W-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] coord_z_i,
  input  logic [COORD_W-1:0] coord_y_i,
  input  logic [COORD_W-1:0] coord_x_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ADDR_W-1:0]  nbr_addr_o,
  output logic [ORD_W-1:0]   ordinal_o,
  output logic               last_o,
  output logic [STAT_W-1:0]  status_o
);

  cfg_t cfg_q;
  job_t push_job, pop_job;
  logic push, pop, full, empty;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_z <= SIZE_W'(1);
      cfg_q.size_y <= SIZE_W'(1);
      cfg_q.size_x <= SIZE_W'(1);
      cfg_q.conn   <= CONN_W'(3);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SIZE_Z: cfg_q.size_z <= cfg_data_i;
        REG_SIZE_Y: cfg_q.size_y <= cfg_data_i;
        REG_SIZE_X: cfg_q.size_x <= cfg_data_i;
        REG_CONN:   cfg_q.conn   <= cfg_data_i[CONN_W-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  vnag_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .coord_z_i  (coord_z_i),
    .coord_y_i  (coord_y_i),
    .coord_x_i  (coord_x_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  vnag_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_job),
    .empty_o (empty)
  );

  vnag_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .nbr_addr_o  (nbr_addr_o),
    .ordinal_o   (ordinal_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule

>>> test/tb_voxel_neighbor_address_gen_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_neighbor_address_gen_unit
// Self-checking bench for the voxel neighbor address generator. A directed
// table covers reset state, volume extremes, saturated and zero sizes, every
// connectivity and the error and empty markers. Random phases follow, each
// with a fresh volume and connectivity. A local neighbor predictor fills a
// queue of expected beats, and every output beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_voxel_neighbor_address_gen_unit
  import vnag_pkg::*;
();

  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 34;
  localparam int DIRECTED_ROWS = 22;

  // One expected output beat
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [ORD_W-1:0]  ord;
    logic              last;
    status_e           status;
  } nbr_beat_t;

  // One directed stimulus row: volume, center, and an optional typed-in marker
  typedef struct {
    int      vz;
    int      vy;
    int      vx;
    int      vc;
    int      cz;
    int      cy;
    int      cx;
    bit      typed;
    status_e st;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [IDX_W-1:0]   cfg_index_i = '0;
  logic [SIZE_W-1:0]  cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [COORD_W-1:0] coord_z_i = '0;
  logic [COORD_W-1:0] coord_y_i = '0;
  logic [COORD_W-1:0] coord_x_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ADDR_W-1:0]  nbr_addr_o;
  logic [ORD_W-1:0]   ordinal_o;
  logic               last_o;
  logic [STAT_W-1:0]  status_o;

  // Local copy of the configuration registers
  logic [SIZE_W-1:0] vol_z = 11'd1;
  logic [SIZE_W-1:0] vol_y = 11'd1;
  logic [SIZE_W-1:0] vol_x = 11'd1;
  logic [CONN_W-1:0] conn_lim = 2'd3;

  nbr_beat_t pending_beats[$];
  int        err_count = 0;
  int        snd_idle_pct = 32;
  int        rcv_idle_pct = 81;

  stim_row_t stim_rows [DIRECTED_ROWS] = '{
    // reset volume 1x1x1: lone voxel, then coordinates past the edge
    '{1, 1, 1, 3, 0, 0, 0, 1'b1, ST_EMPTY},
    '{1, 1, 1, 3, 0, 0, 1, 1'b1, ST_ERROR},
    '{1, 1, 1, 3, 1023, 1023, 1023, 1'b1, ST_ERROR},
    // full 3x3x3 window at each connectivity
    '{3, 3, 3, 3, 1, 1, 1, 1'b0, ST_VALID},
    '{3, 3, 3, 2, 1, 1, 1, 1'b0, ST_VALID},
    '{3, 3, 3, 1, 1, 1, 1, 1'b0, ST_VALID},
    '{3, 3, 3, 0, 1, 1, 1, 1'b1, ST_EMPTY},
    // clipped corners
    '{3, 3, 3, 3, 0, 0, 0, 1'b0, ST_VALID},
    '{3, 3, 3, 3, 2, 2, 2, 1'b0, ST_VALID},
    // zero size rejects everything
    '{0, 5, 5, 3, 0, 0, 0, 1'b1, ST_ERROR},
    // largest volume, then saturated registers
    '{1024, 1024, 1024, 3, 1023, 1023, 1023, 1'b0, ST_VALID},
    '{2047, 2047, 2047, 3, 1023, 1023, 1023, 1'b0, ST_VALID},
    '{2047, 2047, 2047, 3, 0, 0, 0, 1'b0, ST_VALID},
    '{1024, 1024, 1024, 3, 512, 0, 1023, 1'b0, ST_VALID},
    // single row of voxels
    '{1, 1, 1024, 1, 0, 0, 5, 1'b0, ST_VALID},
    '{1, 1, 1024, 1, 0, 0, 0, 1'b0, ST_VALID},
    '{1, 1, 2, 0, 0, 0, 0, 1'b1, ST_EMPTY},
    // uneven volume, each axis just out of range
    '{1000, 3, 7, 2, 999, 2, 6, 1'b0, ST_VALID},
    '{1000, 3, 7, 2, 1000, 0, 0, 1'b1, ST_ERROR},
    '{1000, 3, 7, 2, 0, 3, 0, 1'b1, ST_ERROR},
    '{1000, 3, 7, 2, 0, 0, 7, 1'b1, ST_ERROR},
    '{1024, 1, 1, 3, 1023, 0, 0, 1'b0, ST_VALID}
  };

  voxel_neighbor_address_gen_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .coord_z_i   (coord_z_i),
    .coord_y_i   (coord_y_i),
    .coord_x_i   (coord_x_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .nbr_addr_o  (nbr_addr_o),
    .ordinal_o   (ordinal_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp a size register to the largest supported dimension
  function automatic int eff_size(input logic [SIZE_W-1:0] vol);
    return (vol > MAX_DIM) ? MAX_DIM : int'(vol);
  endfunction

  // Queue a single marker beat
  function automatic void push_marker(input status_e st);
    nbr_beat_t b;
    b.addr   = '0;
    b.ord    = '0;
    b.last   = 1'b1;
    b.status = st;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // Queue the neighbor addresses of one center voxel in z-y-x scan order
  function automatic void predict_neighbors(input logic [COORD_W-1:0] cz,
                                            input logic [COORD_W-1:0] cy,
                                            input logic [COORD_W-1:0] cx);
    int              ez;
    int              ey;
    int              ex;
    int              z;
    int              y;
    int              x;
    int              d;
    int              n;
    longint unsigned plane;
    longint unsigned a;
    nbr_beat_t       b;
    ez = eff_size(vol_z);
    ey = eff_size(vol_y);
    ex = eff_size(vol_x);
    if (int'(cz) >= ez || int'(cy) >= ey || int'(cx) >= ex) begin
      push_marker(ST_ERROR);
      return;
    end
    plane = longint'(ey) * longint'(ex);
    n = 0;
    for (z = int'(cz) - 1; z <= int'(cz) + 1; z++) begin
      for (y = int'(cy) - 1; y <= int'(cy) + 1; y++) begin
        for (x = int'(cx) - 1; x <= int'(cx) + 1; x++) begin
          if (z < 0 || y < 0 || x < 0 || z >= ez || y >= ey || x >= ex) continue;
          d = ((z > int'(cz)) ? z - int'(cz) : int'(cz) - z)
            + ((y > int'(cy)) ? y - int'(cy) : int'(cy) - y)
            + ((x > int'(cx)) ? x - int'(cx) : int'(cx) - x);
          if (d == 0 || d > int'(conn_lim) || n >= WIN_CELLS - 1) continue;
          n++;
          a = longint'(z) * plane + longint'(y) * longint'(ex) + longint'(x);
          b.addr   = a[ADDR_W-1:0];
          b.ord    = n[ORD_W-1:0];
          b.last   = 1'b0;
          b.status = ST_VALID;
          pending_beats.insert(pending_beats.size(), b);
        end
      end
    end
    if (n == 0) begin
      push_marker(ST_EMPTY);
    end else begin
      pending_beats[pending_beats.size()-1].last = 1'b1;
    end
  endfunction

  // Mostly in-range coordinates, biased to the volume edges, with some noise
  function automatic logic [COORD_W-1:0] pick_coord(input logic [SIZE_W-1:0] vol);
    int e;
    int r;
    e = eff_size(vol);
    r = $urandom_range(0, 99);
    if (e == 0 || r < 8) return COORD_W'($urandom_range(0, MAX_DIM - 1));
    if (r < 20) return COORD_W'(e - 1);
    if (r < 28) return '0;
    return COORD_W'($urandom_range(0, e - 1));
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("ERROR @%0t: %s got %0d want %0d", $time, what, got, want);
    err_count++;
  endtask

  // Compare one output beat with the oldest expectation
  task automatic check_beat();
    nbr_beat_t b;
    if (pending_beats.size() == 0) begin
      report_mismatch("beat with nothing pending, address", nbr_addr_o, 0);
      return;
    end
    b = pending_beats.pop_front();
    if (nbr_addr_o !== b.addr)
      report_mismatch("address", nbr_addr_o, b.addr);
    if (ordinal_o !== b.ord) report_mismatch("ordinal", ordinal_o, b.ord);
    if (last_o !== b.last) report_mismatch("last", last_o, b.last);
    if (status_o !== b.status) report_mismatch("status", status_o, b.status);
  endtask

  // Output side: check accepted beats, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_beat();
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Hold off new input until every pending beat has come out
  task automatic drain_beats();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [SIZE_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      REG_SIZE_Z: vol_z = val;
      REG_SIZE_Y: vol_y = val;
      REG_SIZE_X: vol_x = val;
      default:    conn_lim = val[CONN_W-1:0];
    endcase
  endtask

  // Reprogram the whole volume while the block is idle
  task automatic set_volume(input int vz, input int vy, input int vx, input int vc);
    drain_beats();
    write_reg(REG_SIZE_Z, SIZE_W'(vz));
    write_reg(REG_SIZE_Y, SIZE_W'(vy));
    write_reg(REG_SIZE_X, SIZE_W'(vx));
    write_reg(REG_CONN, SIZE_W'(vc));
    cfg_we_i <= 1'b0;
  endtask

  // Present one center voxel and predict its beats once accepted
  task automatic send_voxel(input logic [COORD_W-1:0] cz, input logic [COORD_W-1:0] cy,
                            input logic [COORD_W-1:0] cx, input bit typed,
                            input status_e st);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_z_i  <= cz;
    coord_y_i  <= cy;
    coord_x_i  <= cx;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) begin
      push_marker(st);
    end else begin
      predict_neighbors(cz, cy, cx);
    end
  endtask

  initial begin
    int ph;
    int i;
    int vz;
    int vy;
    int vx;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; reprogram only when the volume or connectivity changes
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (stim_rows[i].vz != int'(vol_z) || stim_rows[i].vy != int'(vol_y) ||
          stim_rows[i].vx != int'(vol_x) || stim_rows[i].vc != int'(conn_lim))
        set_volume(stim_rows[i].vz, stim_rows[i].vy, stim_rows[i].vx, stim_rows[i].vc);
      send_voxel(COORD_W'(stim_rows[i].cz), COORD_W'(stim_rows[i].cy),
                 COORD_W'(stim_rows[i].cx), stim_rows[i].typed, stim_rows[i].st);
    end

    // Random phases: sender idles light then heavy, then no idling at all
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 4)
        0: begin
          snd_idle_pct = 32;
          rcv_idle_pct = 81;
        end
        1: begin
          snd_idle_pct = 81;
          rcv_idle_pct = 32;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      case (ph % 4)
        0: begin
          vz = ($urandom_range(0, 2) == 0) ? 2047 : $urandom_range(1000, 2047);
          vy = ($urandom_range(0, 1) == 0) ? 1024 : $urandom_range(1000, 2047);
          vx = ($urandom_range(0, 2) == 0) ? 1024 : $urandom_range(1000, 2047);
        end
        3: begin
          vz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
          vy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
          vx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
        end
        default: begin
          vz = $urandom_range(1, 12);
          vy = $urandom_range(1, 12);
          vx = $urandom_range(1, 12);
        end
      endcase
      set_volume(vz, vy, vx, (ph % 4 == 0) ? $urandom_range(1, 3) : $urandom_range(0, 3));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_voxel(pick_coord(vol_z), pick_coord(vol_y), pick_coord(vol_x), 1'b0, ST_VALID);
        if ($urandom_range(0, 39) == 0) drain_beats();
      end
    end

    // Let the last beats out, then watch for strays
    drain_beats();
    repeat (40) @(posedge clk_i);
    if (pending_beats.size() != 0)
      report_mismatch("beats still pending", pending_beats.size(), 0);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
src/vnag_pkg.sv
src/vnag_fifo.sv
src/vnag_front.sv
src/vnag_back.sv
src/voxel_neighbor_address_gen_unit.sv
test/tb_voxel_neighbor_address_gen_unit.sv
